// File: src/lpm_pkg.sv
// Shared constants and types for the LIKE pattern matcher.
package lpm_pkg;

    // Default pattern capacity in bytes
    localparam int MAX_PATTERN_DEFAULT = 32;

    // Bytes that the pattern registers can hold
    localparam int REG_BYTES = 32;

    // Pattern metacharacters
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

    // Configuration register indexes
    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_WORD0  = 3'd1;
    localparam logic [2:0] REG_WORD1  = 3'd2;
    localparam logic [2:0] REG_WORD2  = 3'd3;
    localparam logic [2:0] REG_WORD3  = 3'd4;

    // Compiled token kind at a pattern position
    typedef enum logic [1:0] {
        TK_NONE,
        TK_LIT,
        TK_ANY,
        TK_STAR
    } tok_kind_t;

endpackage

// File: src/like_pattern_match.sv
// Streaming SQL LIKE matcher with backslash escape and APB pattern registers.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata text_byte, s_tuser has_byte,
//          |     |                        | s_tlast end_of_text
//  m_*     | out | m_tvalid / m_tready    | m_tdata bit 0 matched
//  apb     | in  | psel, penable, pready  | paddr 8*i, pwdata / prdata 64 bits
//
// One text word is taken every cycle while s_tready is high; a word with
// s_tlast puts its result in the output register in the cycle after it is
// taken. The per-word path is one 33-bit add (the '%' closure) after a bank
// of parallel byte compares. After reset, and after every write to a valid
// register, the pattern is compiled one position per cycle: s_tready stays
// low while the sweep covers MAX_PATTERN (capped at 32) positions. Reset is
// asynchronous, active low. A stalled output holds its word; input keeps
// flowing while the output is free or being drained in the same cycle.
module like_pattern_match #(
    parameter int MAX_PATTERN = lpm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input text stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_text
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Usable pattern bytes and derived widths
    localparam int CAP   = (MAX_PATTERN < lpm_pkg::REG_BYTES) ? MAX_PATTERN
                                                              : lpm_pkg::REG_BYTES;
    localparam int IDX_W = $clog2(CAP);
    localparam int POS_W = $clog2(CAP + 1);

    // ---------------------------------------------------------------- config
    logic [5:0]  plen_reg;
    logic [63:0] pword_reg [4];
    logic        cfg_wr;
    logic        cfg_hit;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (cfg_idx <= lpm_pkg::REG_WORD3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            for (int w = 0; w < 4; w++)
            begin
                pword_reg[w] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lpm_pkg::REG_LENGTH: plen_reg     <= pwdata[5:0];
                lpm_pkg::REG_WORD0:  pword_reg[0] <= pwdata;
                lpm_pkg::REG_WORD1:  pword_reg[1] <= pwdata;
                lpm_pkg::REG_WORD2:  pword_reg[2] <= pwdata;
                lpm_pkg::REG_WORD3:  pword_reg[3] <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lpm_pkg::REG_LENGTH: prdata = {58'd0, plen_reg};
            lpm_pkg::REG_WORD0:  prdata = pword_reg[0];
            lpm_pkg::REG_WORD1:  prdata = pword_reg[1];
            lpm_pkg::REG_WORD2:  prdata = pword_reg[2];
            lpm_pkg::REG_WORD3:  prdata = pword_reg[3];
            default:             prdata = '0;
        endcase
    end

    // --------------------------------------------------------- compile sweep
    // Walk the pattern one byte a cycle and build the token tables. An escape
    // takes the following byte as its literal and skips that position.
    logic [255:0]      pat_flat;
    logic [POS_W-1:0]  len_cap;
    logic [POS_W-1:0]  len_reg;
    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              skip_reg;
    logic              lead_reg;
    logic [CAP:0]      start_vec_reg;

    lpm_pkg::tok_kind_t tk_kind_reg [CAP];
    logic [7:0]         tk_lit_reg  [CAP];
    logic               tk_two_reg  [CAP];

    lpm_pkg::tok_kind_t kind_new;
    logic [7:0]         lit_new;
    logic               two_new;
    logic               skip_next;
    logic               lead_next;
    logic [CAP:0]       start_vec_next;
    logic [7:0]         byte_cur;
    logic [7:0]         byte_nxt;
    logic [IDX_W-1:0]   idx_inc;
    logic [POS_W-1:0]   pos_cur;
    logic [POS_W-1:0]   pos_inc;
    logic               sweep_done;

    assign pat_flat = {pword_reg[3], pword_reg[2], pword_reg[1], pword_reg[0]};
    assign len_cap  = (plen_reg > 6'(CAP)) ? POS_W'(CAP) : POS_W'(plen_reg);

    assign idx_inc    = idx_reg + 1'b1;
    assign pos_cur    = POS_W'(idx_reg);
    assign pos_inc    = pos_cur + 1'b1;
    // The byte after the last position is only looked at when it is in use
    assign byte_cur   = pat_flat[{idx_reg, 3'b000} +: 8];
    assign byte_nxt   = pat_flat[{idx_inc, 3'b000} +: 8];
    assign sweep_done = (idx_reg == IDX_W'(CAP - 1));

    always_comb
    begin
        kind_new       = lpm_pkg::TK_NONE;
        lit_new        = byte_cur;
        two_new        = 1'b0;
        skip_next      = 1'b0;
        lead_next      = 1'b0;
        start_vec_next = start_vec_reg;
        if (pos_cur < len_cap && !skip_reg)
        begin
            if (byte_cur == lpm_pkg::CH_BACKSLASH)
            begin
                kind_new = lpm_pkg::TK_LIT;
                if (pos_inc < len_cap)
                begin
                    // escaped byte is literal
                    lit_new   = byte_nxt;
                    two_new   = 1'b1;
                    skip_next = 1'b1;
                end
            end
            else if (byte_cur == lpm_pkg::CH_PERCENT)
            begin
                kind_new = lpm_pkg::TK_STAR;
            end
            else if (byte_cur == lpm_pkg::CH_UNDERSCORE)
            begin
                kind_new = lpm_pkg::TK_ANY;
            end
            else
            begin
                kind_new = lpm_pkg::TK_LIT;
            end
        end
        // Leading run of '%' extends the start vector
        if (lead_reg && kind_new == lpm_pkg::TK_STAR)
        begin
            lead_next               = 1'b1;
            start_vec_next[pos_inc] = 1'b1;
        end
    end

    // ----------------------------------------------------------- match path
    logic              s_accept;
    logic              has_byte;
    logic [CAP:0]      active_reg;
    logic [CAP:0]      star_mask;
    logic [CAP-1:0]    hit_one;
    logic [CAP-1:0]    hit_two;
    logic [CAP:0]      adv;
    logic [CAP:0]      clos_sum;
    logic [CAP:0]      clos;
    logic [CAP:0]      v_new;
    logic              matched;
    logic              m_valid_reg;
    logic              m_match_reg;

    assign has_byte = s_tuser[0];
    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        star_mask = '0;
        hit_one   = '0;
        hit_two   = '0;
        for (int p = 0; p < CAP; p++)
        begin
            logic hit;
            hit = active_reg[p] &&
                  ((tk_kind_reg[p] == lpm_pkg::TK_ANY) ||
                   (tk_kind_reg[p] == lpm_pkg::TK_LIT && tk_lit_reg[p] == s_tdata));
            star_mask[p] = (tk_kind_reg[p] == lpm_pkg::TK_STAR);
            hit_one[p]   = hit && !tk_two_reg[p];
            hit_two[p]   = hit && tk_two_reg[p];
        end
    end

    // Step every live position by one byte; a '%' holds its own position
    assign adv = (active_reg & star_mask)
               | {hit_one, 1'b0}
               | (CAP + 1)'({hit_two, 2'b00});

    // Closure: a set bit inside a run of '%' positions fills upward to the
    // end of the run plus one. The carry of star + (adv & star) does that fill.
    assign clos_sum = star_mask + (adv & star_mask);
    assign clos     = adv | (clos_sum ^ star_mask);

    assign v_new   = has_byte ? clos : active_reg;
    assign matched = v_new[len_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            idx_reg       <= '0;
            skip_reg      <= 1'b0;
            lead_reg      <= 1'b1;
            start_vec_reg <= (CAP + 1)'(1);
            active_reg    <= (CAP + 1)'(1);
            len_reg       <= '0;
            for (int p = 0; p < CAP; p++)
            begin
                tk_kind_reg[p] <= lpm_pkg::TK_NONE;
                tk_two_reg[p]  <= 1'b0;
            end
        end
        else if (cfg_hit)
        begin
            // restart the sweep on any pattern change
            busy_reg      <= 1'b1;
            idx_reg       <= '0;
            skip_reg      <= 1'b0;
            lead_reg      <= 1'b1;
            start_vec_reg <= (CAP + 1)'(1);
            active_reg    <= (CAP + 1)'(1);
        end
        else if (busy_reg)
        begin
            tk_kind_reg[idx_reg] <= kind_new;
            tk_two_reg[idx_reg]  <= two_new;
            skip_reg             <= skip_next;
            lead_reg             <= lead_next;
            start_vec_reg        <= start_vec_next;
            idx_reg              <= idx_inc;
            if (sweep_done)
            begin
                busy_reg   <= 1'b0;
                idx_reg    <= '0;
                active_reg <= start_vec_next;
                len_reg    <= len_cap;
            end
        end
        else if (s_accept)
        begin
            active_reg <= s_tlast ? start_vec_reg : v_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_hit)
        begin
            tk_lit_reg[idx_reg] <= lit_new;
        end
    end

    // ----------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_accept && s_tlast)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_tlast)
        begin
            m_match_reg <= matched;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_match_reg};

    // ------------------------------------------------------------ checks
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready)
        else $error("input taken during pattern compile");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> busy_reg && idx_reg == '0)
        else $error("register write did not restart compile");

    a_sweep_loads_start: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> active_reg == start_vec_reg && len_reg <= POS_W'(CAP))
        else $error("active vector not loaded from start vector");

    a_no_result_without_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_tlast && !m_valid_reg) |=> !m_valid_reg)
        else $error("result produced without end of text");

endmodule

// File: tb/tb_like_pattern_match.sv
// Self-checking testbench for the streaming LIKE pattern matcher.
`timescale 1ns / 100ps

module tb_like_pattern_match;

    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 6;
    localparam int          RANDOM_WORDS   = 600;
    localparam int          CALM_WORDS     = 100;
    localparam int          LONG_HOLD      = 150;
    localparam int          SETTLE         = 4;
    localparam int          TAIL           = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PRESSURE_PHASE = 4;
    localparam int          DIRECTED_ROWS  = 22;
    // First and last register index that decodes to nothing
    localparam logic [2:0]  REG_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  REG_UNUSED_HI  = 3'd7;
    // Strings cannot carry a zero byte, so the table writes 0x01 in its place
    localparam logic [7:0]  ZERO_STANDIN   = 8'h01;
    // Thirty-one '%' and then an 'x' in byte 31
    localparam string       RUN_OF_STARS   =
        {"%%%%%%%%", "%%%%%%%%", "%%%%%%%%", "%%%%%%%x"};

    typedef enum logic [1:0] {
        FIN_LAST,   // last text byte carries the end mark
        FIN_BARE,   // idle word, then a bare end marker
        FIN_OPEN    // text left unfinished; the next write drops it
    } text_end_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] text_byte
    logic [0:0]  s_tuser;   // [0] has_byte
    logic        s_tlast;   // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] matched, [7:1] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    like_pattern_match i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Matcher state as the testbench sees it: register copies, the
    // compiled tokens and the vector of reached pattern positions.
    // ------------------------------------------------------------------
    logic [5:0]  cfg_len = '0;
    logic [63:0] cfg_word [4] = '{default: '0};
    logic [32:0] reach = 33'd1;

    lpm_pkg::tok_kind_t tok_kind [lpm_pkg::REG_BYTES];
    logic [7:0]         tok_lit  [lpm_pkg::REG_BYTES];
    int                 tok_next [lpm_pkg::REG_BYTES];
    int                 tok_len;

    logic        match_due [$];     // matched bits still to come, oldest first
    logic [7:0]  text_q [$];        // text being built by the random part

    int  mismatches   = 0;
    int  results_seen = 0;
    int  words_sent   = 0;
    int  strings_sent = 0;
    int  reg_writes   = 0;
    int  settings     = 0;
    int  long_holds   = 0;
    int  gap_odds     = 0;
    int  stall_odds   = 0;
    bit  calm         = 1'b0;
    bit  long_hold_req = 1'b0;

    function automatic logic [7:0] pattern_byte(int i);
        return cfg_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    // Turn the pattern registers into tokens; an escape eats the byte after it.
    function automatic void compile_tokens();
        int         cap;
        int         n;
        int         i;
        logic [7:0] b;
        cap = (lpm_pkg::MAX_PATTERN_DEFAULT < lpm_pkg::REG_BYTES)
            ? lpm_pkg::MAX_PATTERN_DEFAULT : lpm_pkg::REG_BYTES;
        n = int'(cfg_len);
        if (n > cap)
            n = cap;
        tok_len = n;
        for (i = 0; i < lpm_pkg::REG_BYTES; i++)
        begin
            tok_kind[i] = lpm_pkg::TK_NONE;
            tok_lit[i]  = '0;
            tok_next[i] = 0;
        end
        i = 0;
        while (i < n)
        begin
            b = pattern_byte(i);
            if (b == lpm_pkg::CH_BACKSLASH)
            begin
                tok_kind[i] = lpm_pkg::TK_LIT;
                if (i + 1 == n)
                begin
                    // lone trailing backslash stands for itself
                    tok_lit[i]  = lpm_pkg::CH_BACKSLASH;
                    tok_next[i] = i + 1;
                    i = i + 1;
                end
                else
                begin
                    tok_lit[i]  = pattern_byte(i + 1);
                    tok_next[i] = i + 2;
                    i = i + 2;
                end
            end
            else
            begin
                if (b == lpm_pkg::CH_PERCENT)
                    tok_kind[i] = lpm_pkg::TK_STAR;
                else if (b == lpm_pkg::CH_UNDERSCORE)
                    tok_kind[i] = lpm_pkg::TK_ANY;
                else
                    tok_kind[i] = lpm_pkg::TK_LIT;
                tok_lit[i]  = b;
                tok_next[i] = i + 1;
                i = i + 1;
            end
        end
    endfunction

    // A reached '%' also reaches the position right after it; ascending
    // order lets a run of '%' pass the bit along in one sweep.
    function automatic logic [32:0] star_reach(logic [32:0] v);
        int i;
        for (i = 0; i < tok_len; i++)
            if (v[i] && tok_kind[i] == lpm_pkg::TK_STAR)
                v[i + 1] = 1'b1;
        return v;
    endfunction

    // Advance the position vector by one word; return the matched bit on an
    // end mark, else -1.
    function automatic int predict_word(logic [7:0] c, bit has, bit last);
        logic [32:0] v;
        logic [32:0] nx;
        int          i;
        compile_tokens();
        v = star_reach(reach);
        if (has)
        begin
            nx = '0;
            for (i = 0; i < tok_len; i++)
            begin
                if (v[i])
                begin
                    if (tok_kind[i] == lpm_pkg::TK_STAR)
                        nx[i] = 1'b1;
                    else if (tok_kind[i] == lpm_pkg::TK_ANY ||
                             (tok_kind[i] == lpm_pkg::TK_LIT && tok_lit[i] == c))
                        nx[tok_next[i]] = 1'b1;
                end
            end
            v = star_reach(nx);
        end
        reach = v;
        if (!last)
            return -1;
        reach = 33'd1;
        return int'(v[tok_len]);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0, 2:    return "a";
            1:       return "b";
            3:       return lpm_pkg::CH_PERCENT;
            4:       return lpm_pkg::CH_UNDERSCORE;
            5:       return lpm_pkg::CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] table_byte(logic [7:0] ch);
        return (ch == ZERO_STANDIN) ? 8'h00 : ch;
    endfunction

    task automatic note_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("tb: result %0d field %s got %0h expected %0h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Bus drivers
    // ------------------------------------------------------------------

    // Offer one text word, hold it until taken, then advance the prediction.
    // forced >= 0 overrides the predicted bit with a value from the table.
    task automatic send_word(logic [7:0] c, bit has, bit last, int forced);
        int r;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_word(c, has, last);
        if (r >= 0)
        begin
            match_due.push_back((forced >= 0) ? forced[0] : r[0]);
            strings_sent++;
        end
        if (has || last)
            words_sent++;
    endtask

    // Drop valid and wait until every result is back and the block is quiet.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (match_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Setup phase, access phase, then idle; mirror a decoded write into the
    // register copies.
    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
        if (idx == lpm_pkg::REG_LENGTH)
            cfg_len = val[5:0];
        else if (idx <= lpm_pkg::REG_WORD3)
            cfg_word[idx - lpm_pkg::REG_WORD0] = val;
        else
            return;
        // any decoded write restarts the text in progress
        reach = 33'd1;
    endtask

    // ------------------------------------------------------------------
    // Directed table: whether a new pattern is written, pattern, length (-1 =
    // pattern size), text, how the text ends, a write to an unused index after
    // the first byte, and the expected bit (-1 = take the predictor's).
    // ------------------------------------------------------------------
    bit        d_cfg [DIRECTED_ROWS] = '{
        0, 0, 1, 0, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1};
    string     d_pat [DIRECTED_ROWS] = '{
        "", "", "abc", "", "a%c", "", "%_%", "_\377", "__", "a\\%b", "",
        "ab\\", "\\_", "\001\377%", RUN_OF_STARS, RUN_OF_STARS, "abc", "abc",
        "abc", "", "a%b%c", "%\\\\%"};
    int        d_len [DIRECTED_ROWS] = '{
        -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
        -1, -1, -1, 63, 31, 0, -1, -1, -1, -1, -1};
    string     d_text [DIRECTED_ROWS] = '{
        "", "a", "abc", "abd", "aXYZc", "ac", "", "\377\377", "a", "a%b", "aXb",
        "ab\\", "x", "\001\377\001", "y", "y", "", "ab", "c", "abc", "abxbyc",
        "x\\y"};
    text_end_t d_fin [DIRECTED_ROWS] = '{
        FIN_BARE, FIN_LAST, FIN_LAST, FIN_LAST, FIN_LAST, FIN_BARE, FIN_BARE,
        FIN_LAST, FIN_LAST, FIN_LAST, FIN_LAST, FIN_LAST, FIN_LAST, FIN_LAST,
        FIN_LAST, FIN_LAST, FIN_BARE, FIN_OPEN, FIN_LAST, FIN_LAST, FIN_LAST,
        FIN_LAST};
    bit        d_bad [DIRECTED_ROWS] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0};
    int        d_exp [DIRECTED_ROWS] = '{
        1, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1, -1, 0, 1, -1, -1};

    // ------------------------------------------------------------------
    // Stimulus: reset, directed rows, then random pattern phases.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          row;
        int          k;
        int          w;
        int          n;
        int          phase;
        int          ntexts;
        int          t;
        int          i;
        int          mode;
        bit          pressure;
        bit          noise;
        bit          end_on_byte;
        bit          leave_open;
        string       s;
        logic [63:0] words [4];
        logic [63:0] val;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows with light idling on both sides
        gap_odds   = 5;
        stall_odds = 5;
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (d_cfg[row])
            begin
                wait_for_results();
                s = d_pat[row];
                for (w = 0; w < 4; w++)
                    words[w] = '0;
                for (i = 0; i < s.len(); i++)
                    words[i >> 3][(i & 7) * 8 +: 8] = table_byte(s[i]);
                n = (d_len[row] < 0) ? s.len() : d_len[row];
                apb_write(lpm_pkg::REG_LENGTH, 64'(n));
                for (w = 0; w < 4; w++)
                    apb_write(lpm_pkg::REG_WORD0 + 3'(w), words[w]);
                settings++;
            end
            s = d_text[row];
            for (k = 0; k < s.len(); k++)
            begin
                send_word(table_byte(s[k]), 1'b1,
                          d_fin[row] == FIN_LAST && k == s.len() - 1, d_exp[row]);
                if (d_bad[row] && k == 0)
                begin
                    // a write to an unused index must leave the text running
                    wait_for_results();
                    apb_write(REG_UNUSED_LO, {$urandom(), $urandom()});
                end
            end
            if (d_fin[row] == FIN_BARE)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, -1);
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, d_exp[row]);
            end
        end

        // Random phases: new register contents, then a batch of texts
        phase = 0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            wait_for_results();
            pressure = (phase == PRESSURE_PHASE);
            noise = ($urandom_range(0, 6) == 0);
            for (w = 0; w < 4; w++)
                for (k = 0; k < 8; k++)
                    words[w][k * 8 +: 8] = noise ? 8'($urandom_range(0, 255))
                                                 : pick_byte();
            mode = $urandom_range(0, 9);
            if (mode == 0)
                n = 0;
            else if (mode == 1)
            begin
                case ($urandom_range(0, 2))
                    0:       n = lpm_pkg::REG_BYTES;
                    1:       n = 63;
                    default: n = $urandom_range(lpm_pkg::REG_BYTES - 7, 62);
                endcase
            end
            else
                n = $urandom_range(1, 8);
            // keep at least the length write; a skipped word register keeps its old contents
            val = {$urandom(), $urandom()};
            val[5:0] = 6'(n);
            apb_write(lpm_pkg::REG_LENGTH, val);
            for (w = 0; w < 4; w++)
                if (phase == 0 || $urandom_range(0, 2) != 0)
                    apb_write(lpm_pkg::REG_WORD0 + 3'(w), words[w]);
            if ($urandom_range(0, 4) == 0)
                apb_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          {$urandom(), $urandom()});
            settings++;

            if (calm || pressure)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    default: gap_odds = 12;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    default: stall_odds = 12;
                endcase
            end

            // Hold the result side off while short texts keep arriving
            if (pressure)
                long_hold_req = 1'b1;

            ntexts = pressure ? 24 : $urandom_range(2, 8);
            for (t = 0; t < ntexts; t++)
            begin
                text_q.delete();
                if (pressure)
                    repeat ($urandom_range(1, 2)) text_q.push_back(pick_byte());
                else if ($urandom_range(0, 3) != 0)
                begin
                    // walk the tokens to build a text that fits the pattern
                    compile_tokens();
                    i = 0;
                    while (i < tok_len)
                    begin
                        case (tok_kind[i])
                            lpm_pkg::TK_STAR:
                            begin
                                repeat ($urandom_range(0, 3)) text_q.push_back(pick_byte());
                                i = i + 1;
                            end
                            lpm_pkg::TK_ANY:
                            begin
                                text_q.push_back(pick_byte());
                                i = i + 1;
                            end
                            default:
                            begin
                                text_q.push_back(tok_lit[i]);
                                i = (tok_next[i] > i) ? tok_next[i] : i + 1;
                            end
                        endcase
                    end
                    // break some of them
                    if ($urandom_range(0, 3) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:
                                if (text_q.size() != 0)
                                    text_q[$urandom_range(0, text_q.size() - 1)] = pick_byte();
                            1:       text_q.push_back(pick_byte());
                            default:
                                if (text_q.size() != 0)
                                    void'(text_q.pop_back());
                        endcase
                    end
                end
                else
                    repeat ($urandom_range(0, 10)) text_q.push_back(pick_byte());

                leave_open  = !pressure && t == ntexts - 1 && $urandom_range(0, 4) == 0;
                end_on_byte = !leave_open && text_q.size() != 0 &&
                              $urandom_range(0, 5) != 0;
                for (k = 0; k < text_q.size(); k++)
                begin
                    if (!pressure && $urandom_range(0, 9) == 0)
                        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, -1);
                    send_word(text_q[k], 1'b1, end_on_byte && k == text_q.size() - 1, -1);
                end
                if (!end_on_byte && !leave_open)
                    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, -1);
            end

            phase++;
            if (words_sent > RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
        end

        // Drain, let the pipeline settle, then report
        wait_for_results();
        repeat (TAIL) @(posedge clk);
        $display("summary: %0d strings, %0d results checked, %0d long hold(s)",
                 strings_sent, results_seen, long_holds);
        $display("summary: %0d register writes over %0d pattern settings, %0d mismatches",
                 reg_writes, settings, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, one long hold on request, and no
    // stalls once the run turns calm.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                long_holds++;
                m_tready <= 1'b1;
            end
            else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare every result word with the oldest expected matched bit.
    always @(posedge clk)
    begin : result_check
        logic want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (match_due.size() == 0)
                note_mismatch("matched (none expected)", m_tdata, 8'hxx);
            else
            begin
                want = match_due.pop_front();
                if (m_tdata[0] !== want)
                    note_mismatch("matched", {7'd0, m_tdata[0]}, {7'd0, want});
                if (m_tdata[7:1] !== 7'd0)
                    note_mismatch("pad", {1'b0, m_tdata[7:1]}, 8'h00);
            end
        end
    end

    // Stop the run if no word moves on any port for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
src/lpm_pkg.sv
src/like_pattern_match.sv
tb/tb_like_pattern_match.sv
